FILE: hdl/jsonc_comment_stripper_top_defines.svh
// assertion macros shared by the comment stripper modules
`ifndef JSONC_COMMENT_STRIPPER_TOP_DEFINES_SVH
`define JSONC_COMMENT_STRIPPER_TOP_DEFINES_SVH

// condition and consequence in the same cycle
`define JCS_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// consequence in the cycle after the condition
`define JCS_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

FILE: hdl/jcs_pkg.sv
// shared types and constants of the comment stripper
package jcs_pkg;

	localparam logic [7:0] CH_QUOTE  = 8'h22;
	localparam logic [7:0] CH_BSLASH = 8'h5C;
	localparam logic [7:0] CH_SLASH  = 8'h2F;
	localparam logic [7:0] CH_STAR   = 8'h2A;
	localparam logic [7:0] CH_NL     = 8'h0A;
	localparam logic [7:0] CH_SPACE  = 8'h20;

	localparam logic [1:0] CNT_NONE = 2'd0;
	localparam logic [1:0] CNT_ONE  = 2'd1;
	localparam logic [1:0] CNT_TWO  = 2'd2;

	// scan modes, one-hot
	typedef enum logic [6:0] {
		M_NORMAL     = 7'b0000001,
		M_STR        = 7'b0000010,
		M_STR_ESC    = 7'b0000100,
		M_SLASH      = 7'b0001000,
		M_LINE       = 7'b0010000,
		M_BLOCK      = 7'b0100000,
		M_BLOCK_STAR = 7'b1000000
	} mode_t;

	// results caused by one item: count, first and second byte
	typedef struct packed {
		logic [1:0] cnt;
		logic [7:0] b0;
		logic [7:0] b1;
	} res_t;

endpackage

FILE: hdl/jcs_scanner.sv
// scan mode register and per-item comment stripping logic
`include "jsonc_comment_stripper_top_defines.svh"

module jcs_scanner (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               accept,
	input  logic [7:0]         byte_i,
	input  logic               last_i,
	output jcs_pkg::res_t      res
);

	jcs_pkg::mode_t mode_q;
	jcs_pkg::mode_t nxt;
	logic           is_quote;
	logic           is_slash;
	logic           is_star;
	logic           is_nl;
	logic [7:0]     body_ch;

	assign is_quote = (byte_i == jcs_pkg::CH_QUOTE);
	assign is_slash = (byte_i == jcs_pkg::CH_SLASH);
	assign is_star  = (byte_i == jcs_pkg::CH_STAR);
	assign is_nl    = (byte_i == jcs_pkg::CH_NL);
	// block comment body: newline kept, anything else blanked
	assign body_ch  = is_nl ? jcs_pkg::CH_NL : jcs_pkg::CH_SPACE;

	// results and next mode for the item at the input
	always_comb begin
		res.cnt = jcs_pkg::CNT_NONE;
		res.b0  = byte_i;
		res.b1  = byte_i;
		nxt     = mode_q;
		unique case (mode_q)
			jcs_pkg::M_STR: begin
				res.cnt = jcs_pkg::CNT_ONE;
				if (byte_i == jcs_pkg::CH_BSLASH) begin
					nxt = jcs_pkg::M_STR_ESC;
				end else if (is_quote) begin
					nxt = jcs_pkg::M_NORMAL;
				end
			end
			jcs_pkg::M_STR_ESC: begin
				res.cnt = jcs_pkg::CNT_ONE;
				nxt     = jcs_pkg::M_STR;
			end
			jcs_pkg::M_SLASH: begin
				if (is_slash) begin
					nxt = jcs_pkg::M_LINE;
				end else if (is_star) begin
					nxt = jcs_pkg::M_BLOCK;
				end else begin
					// held slash first, then the byte as normal text
					res.b0  = jcs_pkg::CH_SLASH;
					res.cnt = jcs_pkg::CNT_TWO;
					nxt     = is_quote ? jcs_pkg::M_STR : jcs_pkg::M_NORMAL;
				end
			end
			jcs_pkg::M_LINE: begin
				if (is_nl) begin
					res.cnt = jcs_pkg::CNT_ONE;
					nxt     = jcs_pkg::M_NORMAL;
				end
			end
			jcs_pkg::M_BLOCK: begin
				if (!last_i) begin
					if (is_star) begin
						nxt = jcs_pkg::M_BLOCK_STAR;
					end else begin
						res.b0  = body_ch;
						res.cnt = jcs_pkg::CNT_ONE;
					end
				end
			end
			jcs_pkg::M_BLOCK_STAR: begin
				if (is_slash) begin
					nxt = jcs_pkg::M_NORMAL;
				end else begin
					// held star becomes a space
					res.b0  = jcs_pkg::CH_SPACE;
					res.cnt = jcs_pkg::CNT_ONE;
					nxt     = jcs_pkg::M_BLOCK;
					if (!last_i) begin
						if (is_star) begin
							nxt = jcs_pkg::M_BLOCK_STAR;
						end else begin
							res.b1  = body_ch;
							res.cnt = jcs_pkg::CNT_TWO;
						end
					end
				end
			end
			default: begin
				// normal text, also any code outside the mode set
				nxt = jcs_pkg::M_NORMAL;
				if (is_quote) begin
					res.cnt = jcs_pkg::CNT_ONE;
					nxt     = jcs_pkg::M_STR;
				end else if (is_slash && !last_i) begin
					nxt = jcs_pkg::M_SLASH;
				end else begin
					res.cnt = jcs_pkg::CNT_ONE;
				end
			end
		endcase
		if (last_i) begin
			nxt = jcs_pkg::M_NORMAL;
		end
	end

	// mode register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= jcs_pkg::M_NORMAL;
		end else if (accept) begin
			mode_q <= nxt;
		end
	end

	`JCS_ASSERT_NEXT(a_last_resets_mode, accept && last_i, mode_q == jcs_pkg::M_NORMAL,
		"mode not back to normal after the final item")
	`JCS_ASSERT_NOW(a_mode_onehot, 1'b1, $onehot(mode_q), "scan mode not one-hot")
	`JCS_ASSERT_NOW(a_cnt_range, accept, res.cnt != 2'd3, "more than two results for one item")

endmodule

FILE: hdl/jcs_outbuf.sv
// two-slot result buffer that hands out one byte per cycle while out_ready is high
`include "jsonc_comment_stripper_top_defines.svh"

module jcs_outbuf (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  jcs_pkg::res_t res,
	output logic          space_ok,
	output logic          out_valid,
	input  logic          out_ready,
	output logic [7:0]    out_byte,
	output logic          run_last
);

	jcs_pkg::res_t slot_q [2];
	logic          wr_q;
	logic          rd_q;
	logic [1:0]    count_q;
	logic          sub_q;
	jcs_pkg::res_t head;
	logic          head_end;
	logic          do_push;
	logic          do_pop;
	logic          pop_slot;

	assign do_push  = push && (res.cnt != jcs_pkg::CNT_NONE);
	assign head     = slot_q[rd_q];
	// second byte of a pair, or the only byte, ends the item's run
	assign head_end = (head.cnt != jcs_pkg::CNT_TWO) || sub_q;
	assign out_valid = (count_q != 2'd0);
	assign out_byte  = sub_q ? head.b1 : head.b0;
	assign run_last  = head_end;
	assign do_pop    = out_valid && out_ready;
	assign pop_slot  = do_pop && head_end;
	assign space_ok  = (count_q != 2'd2);

	// slot payload
	always_ff @(posedge clk) begin
		if (do_push) begin
			slot_q[wr_q] <= res;
		end
	end

	// pointers, fill count and byte index within the head slot
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= 1'b0;
			rd_q    <= 1'b0;
			count_q <= 2'd0;
			sub_q   <= 1'b0;
		end else begin
			if (do_push) begin
				wr_q <= ~wr_q;
			end
			if (pop_slot) begin
				rd_q <= ~rd_q;
			end
			if (do_pop) begin
				sub_q <= ~head_end;
			end
			if (do_push && !pop_slot) begin
				count_q <= count_q + 2'd1;
			end else if (!do_push && pop_slot) begin
				count_q <= count_q - 2'd1;
			end
		end
	end

	`JCS_ASSERT_NOW(a_count_range, 1'b1, count_q != 2'd3, "result buffer overfilled")
	`JCS_ASSERT_NOW(a_no_push_full, do_push, count_q != 2'd2, "push into a full buffer")
	`JCS_ASSERT_NOW(a_sub_pair, sub_q, out_valid && head.cnt == jcs_pkg::CNT_TWO,
		"second byte index on a slot without a pair")

endmodule

FILE: hdl/jsonc_comment_stripper_top.sv
// JSON-with-comments stripper: top level
//
// Input channel in_valid/in_ready carries one text byte per item (in_byte),
// with in_last set on the final byte of a text. Output channel
// out_valid/out_ready carries the stripped text one byte per item
// (out_byte), with run_last set on the last byte caused by an input item.
// An input item causes zero, one or two output items.
// Results of an input item are registered in the result buffer before they
// reach the output. Throughput: one input item per cycle while each causes
// at most one byte and out_ready is high; the two-slot result buffer drains one
// byte per cycle while out_ready is high; a two-byte item keeps its slot longer.
// in_ready depends only on the buffer fill: low when both slots hold results.
// A stalled receiver fills the buffer and then holds in_ready low.
// Reset (arst_n low) empties the buffer and returns the scan mode to normal
// text with nothing pending; the final item of a text returns the mode to normal.
module jsonc_comment_stripper_top (
	input  logic       clk,
	input  logic       arst_n,
	input  logic       in_valid,
	output logic       in_ready,
	input  logic [7:0] in_byte,
	input  logic       in_last,
	output logic       out_valid,
	input  logic       out_ready,
	output logic [7:0] out_byte,
	output logic       run_last
);

	logic          accept;
	jcs_pkg::res_t res;

	assign accept = in_valid && in_ready;

	// per-item scan logic and mode register
	jcs_scanner u_scanner (
		.clk    (clk),
		.arst_n (arst_n),
		.accept (accept),
		.byte_i (in_byte),
		.last_i (in_last),
		.res    (res)
	);

	// result buffer towards the output channel
	jcs_outbuf u_outbuf (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (accept),
		.res       (res),
		.space_ok  (in_ready),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_byte  (out_byte),
		.run_last  (run_last)
	);

endmodule
